// ----- hdl/algf_pkg.sv -----
// shared types, codes and helpers of the adjacent line group filter
package algf_pkg;

   localparam int LINE_BYTES_DEFAULT = 4096;
   localparam int COUNT_W = 32;
   localparam int OP_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 4;

   // input function codes
   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_EOL  = 2'd1;
   localparam logic [1:0] FUNC_EOS  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ONLY_REPEATED = 2'd0;
   localparam logic [1:0] CSR_ONLY_SINGLE   = 2'd1;
   localparam logic [1:0] CSR_FOLD_CASE     = 2'd2;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_EOL,
      OP_EOS
   } op_kind_type;

   typedef struct packed {
      logic only_repeated;
      logic only_single;
      logic fold_case;
   } cfg_type;

   // classified operation handed from the front to the back
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  byte_value;
      logic        cmp_valid;   // byte lies inside the stored line
      logic        len_miss;    // byte lies beyond the stored line
      logic        do_close;    // the item completes a line
      logic        first_line;  // no group open when the line completes
      logic        len_eq;      // completed line has the stored length
      logic        emit_group;  // end of stream with a group to flush
   } op_type;

   typedef struct packed {
      logic [COUNT_W-1:0] group_count;
      logic               keep;
      logic               last;
   } rsp_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic keep_flag(input logic [COUNT_W-1:0] cnt, input cfg_type cfg);
      logic more_than_one;
      logic exactly_one;
      more_than_one = cnt > COUNT_W'(1);
      exactly_one = cnt == COUNT_W'(1);
      return (!cfg.only_repeated || more_than_one) && (!cfg.only_single || exactly_one);
   endfunction

endpackage

// ----- hdl/algf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module algf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/algf_op_queue.sv -----
// short queue of classified operations between front and back
module algf_op_queue #(
   parameter int ADDR_W = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  algf_pkg::op_type       push_op,
   input  logic [ADDR_W-1:0]      push_addr,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output algf_pkg::op_type       head_op,
   output logic [ADDR_W-1:0]      head_addr
);
   import algf_pkg::*;

   localparam int PTR_W = $clog2(OP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(OP_QUEUE_DEPTH + 1);

   op_type            op_ff   [OP_QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_ff [OP_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = cnt_ff == CNT_W'(OP_QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op   = op_ff[rp_ff];
   assign head_addr = addr_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + PTR_W'(1) : wp_ff;
      rp_in  = do_pop ? rp_ff + PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         op_ff[wp_ff]   <= push_op;
         addr_ff[wp_ff] <= push_addr;
      end
   end

endmodule

// ----- hdl/algf_front.sv -----
// front: accepts input transactions, tracks line lengths and classifies each item
module algf_front #(
   parameter int LINE_BYTES = algf_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_func,
   input  logic [7:0]                    req_byte_value,
   output logic                          op_push,
   output algf_pkg::op_type              op,
   output logic [$clog2(LINE_BYTES)-1:0] op_addr,
   input  logic                          op_full
);
   import algf_pkg::*;

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] CLOSE_LEN = LEN_W'(LINE_BYTES - 1);

   logic [LEN_W-1:0] inc_len_ff, inc_len_in;
   logic [LEN_W-1:0] stored_len_ff, stored_len_in;
   logic             open_ff, open_in;
   logic [LEN_W-1:0] new_len;
   logic             accept;

   assign req_full = op_full;
   assign accept   = req_push && !op_full;
   assign new_len  = inc_len_ff + LEN_W'(1);
   assign op_addr  = inc_len_ff;

   always_comb begin
      inc_len_in    = inc_len_ff;
      stored_len_in = stored_len_ff;
      open_in       = open_ff;
      op_push       = 1'b0;
      op            = '0;
      op.byte_value = req_byte_value;
      op.first_line = !open_ff;
      unique case (req_func)
         FUNC_BYTE: begin
            op_push      = accept;
            op.kind      = OP_BYTE;
            op.cmp_valid = open_ff && (inc_len_ff < stored_len_ff);
            op.len_miss  = open_ff && (inc_len_ff >= stored_len_ff);
            op.do_close  = new_len >= CLOSE_LEN;
            op.len_eq    = new_len == stored_len_ff;
            if (accept) begin
               if (op.do_close) begin
                  stored_len_in = new_len;
                  inc_len_in    = '0;
                  open_in       = 1'b1;
               end else begin
                  inc_len_in = new_len;
               end
            end
         end
         FUNC_EOL: begin
            op_push     = accept;
            op.kind     = OP_EOL;
            op.do_close = 1'b1;
            op.len_eq   = inc_len_ff == stored_len_ff;
            if (accept) begin
               stored_len_in = inc_len_ff;
               inc_len_in    = '0;
               open_in       = 1'b1;
            end
         end
         FUNC_EOS: begin
            op_push       = accept;
            op.kind       = OP_EOS;
            op.do_close   = inc_len_ff != '0;
            op.len_eq     = inc_len_ff == stored_len_ff;
            op.emit_group = open_ff || (inc_len_ff != '0);
            if (accept) begin
               stored_len_in = '0;
               inc_len_in    = '0;
               open_in       = 1'b0;
            end
         end
         default: begin
            // unused code: taken and dropped
            op_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_len_ff    <= '0;
         stored_len_ff <= '0;
         open_ff       <= 1'b0;
      end else begin
         inc_len_ff    <= inc_len_in;
         stored_len_ff <= stored_len_in;
         open_ff       <= open_in;
      end
   end

   // a line in progress never reaches the self-closing length
   assert property (@(posedge clock) disable iff (reset) inc_len_ff < CLOSE_LEN)
      else $error("line in progress reached closing length");

   // a group is open whenever a line has been stored
   assert property (@(posedge clock) disable iff (reset)
      (stored_len_ff != '0) |-> open_ff)
      else $error("stored line without open group");

endmodule

// ----- hdl/algf_back.sv -----
// back: compares bytes against the line store, counts groups and queues results
module algf_back #(
   parameter int LINE_BYTES = algf_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  algf_pkg::cfg_type             cfg,
   input  logic                          op_empty,
   input  algf_pkg::op_type              head_op,
   input  logic [$clog2(LINE_BYTES)-1:0] head_addr,
   output logic                          op_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [31:0]                   rsp_group_count,
   output logic                          rsp_keep,
   output logic                          rsp_last
);
   import algf_pkg::*;

   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam int RP_W   = $clog2(RSP_QUEUE_DEPTH);
   localparam int RC_W   = $clog2(RSP_QUEUE_DEPTH + 1);

   // execute stage
   logic               a_valid_ff, a_valid_in;
   op_type             a_op_ff;
   logic [ADDR_W-1:0]  a_addr_ff;
   logic               fwd_ff;
   logic [7:0]         fwd_data_ff;
   logic               mis_ff, mis_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // result queue
   rsp_type            rq_ff [RSP_QUEUE_DEPTH];
   logic [RP_W-1:0]    rq_wp_ff, rq_wp_in, rq_rp_ff, rq_rp_in;
   logic [RC_W-1:0]    rq_cnt_ff, rq_cnt_in;

   logic               room, complete, advance;
   logic               ram_we;
   logic [7:0]         ram_rdata, stored_byte;
   logic               miss_now, mis_eff, line_equal, close_emit;
   logic [COUNT_W-1:0] count_sat, count_close;
   rsp_type            e0, e1;
   logic [1:0]         n_push;
   logic               do_rsp_pop;

   assign room     = rq_cnt_ff <= RC_W'(RSP_QUEUE_DEPTH - 2);
   assign complete = a_valid_ff && room;
   assign advance  = !a_valid_ff || complete;
   assign op_pop   = advance && !op_empty;
   assign ram_we   = complete && (a_op_ff.kind == OP_BYTE);

   algf_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (a_addr_ff),
      .wr_data (a_op_ff.byte_value),
      .rd_en   (op_pop),
      .rd_addr (head_addr),
      .rd_data (ram_rdata)
   );

   // a read that meets the write of the same entry takes the new byte
   assign stored_byte = fwd_ff ? fwd_data_ff : ram_rdata;

   always_comb begin
      miss_now    = a_op_ff.len_miss ||
                    (a_op_ff.cmp_valid &&
                     fold_byte(stored_byte, cfg.fold_case) !=
                     fold_byte(a_op_ff.byte_value, cfg.fold_case));
      mis_eff     = mis_ff || ((a_op_ff.kind == OP_BYTE) && miss_now);
      line_equal  = !mis_eff && a_op_ff.len_eq;
      count_sat   = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);
      close_emit  = a_op_ff.do_close && !a_op_ff.first_line && !line_equal;
      count_close = count_ff;
      if (a_op_ff.do_close) begin
         count_close = (!a_op_ff.first_line && line_equal) ? count_sat : COUNT_W'(1);
      end

      e0.group_count = close_emit ? count_ff : count_close;
      e0.keep        = keep_flag(e0.group_count, cfg);
      e0.last        = !(close_emit && a_op_ff.emit_group);
      e1.group_count = count_close;
      e1.keep        = keep_flag(count_close, cfg);
      e1.last        = 1'b1;
      n_push = complete ? 2'(close_emit) + 2'(a_op_ff.emit_group) : 2'd0;

      mis_in   = mis_ff;
      count_in = count_ff;
      if (complete) begin
         if (a_op_ff.kind == OP_EOS) begin
            mis_in   = 1'b0;
            count_in = '0;
         end else begin
            mis_in   = a_op_ff.do_close ? 1'b0 : mis_eff;
            count_in = count_close;
         end
      end
      a_valid_in = advance ? !op_empty : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         mis_ff     <= 1'b0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         mis_ff     <= mis_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         a_op_ff     <= head_op;
         a_addr_ff   <= head_addr;
         fwd_ff      <= ram_we && (a_addr_ff == head_addr);
         fwd_data_ff <= a_op_ff.byte_value;
      end
   end

   // result queue, up to two entries written per transaction
   assign rsp_empty       = rq_cnt_ff == '0;
   assign do_rsp_pop      = rsp_pop && !rsp_empty;
   assign rsp_group_count = rq_ff[rq_rp_ff].group_count;
   assign rsp_keep        = rq_ff[rq_rp_ff].keep;
   assign rsp_last        = rq_ff[rq_rp_ff].last;

   always_comb begin
      rq_wp_in  = rq_wp_ff + RP_W'(n_push);
      rq_rp_in  = do_rsp_pop ? rq_rp_ff + RP_W'(1) : rq_rp_ff;
      rq_cnt_in = rq_cnt_ff + RC_W'(n_push) - RC_W'(do_rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wp_ff  <= '0;
         rq_rp_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wp_ff  <= rq_wp_in;
         rq_rp_ff  <= rq_rp_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         rq_ff[rq_wp_ff] <= e0;
      end
      if (n_push == 2'd2) begin
         rq_ff[rq_wp_ff + RP_W'(1)] <= e1;
      end
   end

   // result queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= RC_W'(RSP_QUEUE_DEPTH))
      else $error("result queue overflow");

   // a queued group always holds at least one line
   assert property (@(posedge clock) disable iff (reset)
      (n_push != 2'd0) |-> (e0.group_count != '0))
      else $error("empty group emitted");

   // a stalled item keeps its operation and counter
   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !room) |=> ($stable(a_op_ff) && $stable(count_ff)))
      else $error("stalled item changed");

endmodule

// ----- hdl/adjacent_line_group_filter_top.sv -----
// top level of the adjacent line group filter
// Takes one text byte, end-of-line or end-of-stream transaction per cycle
// while req_full is low and compares each line with the stored previous line; a
// group closed by a differing line, or flushed at end of stream, yields one result
// transaction (at most two per input, the last one flagged). Sustained rate is
// one input per cycle while the result queue has room: the back end reads one
// line-store byte, compares it and writes the new byte in the same entry each
// cycle, with a forward path for a read that hits the entry being written. A
// result passes through the operation queue, the line-store read and the
// compare and count into the result queue before it reaches the output ports.
// The line store holds LINE_BYTES bytes and needs no clearing; lines of
// LINE_BYTES-1 bytes close by themselves. Configuration writes are taken every
// cycle and should only be issued while the block idles.
module adjacent_line_group_filter_top #(
   parameter int LINE_BYTES = algf_pkg::LINE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_group_count,
   output logic        rsp_keep,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_data
);
   import algf_pkg::*;

   localparam int ADDR_W = $clog2(LINE_BYTES);

   cfg_type           cfg_ff, cfg_in;
   logic              op_push, op_full, op_empty, op_pop;
   op_type            front_op, head_op;
   logic [ADDR_W-1:0] front_addr, head_addr;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ONLY_REPEATED: cfg_in.only_repeated = csr_data;
            CSR_ONLY_SINGLE:   cfg_in.only_single   = csr_data;
            CSR_FOLD_CASE:     cfg_in.fold_case     = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   algf_front #(
      .LINE_BYTES (LINE_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_byte_value (req_byte_value),
      .op_push        (op_push),
      .op             (front_op),
      .op_addr        (front_addr),
      .op_full        (op_full)
   );

   algf_op_queue #(
      .ADDR_W (ADDR_W)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_op   (front_op),
      .push_addr (front_addr),
      .full      (op_full),
      .pop       (op_pop),
      .empty     (op_empty),
      .head_op   (head_op),
      .head_addr (head_addr)
   );

   algf_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .op_empty        (op_empty),
      .head_op         (head_op),
      .head_addr       (head_addr),
      .op_pop          (op_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_group_count (rsp_group_count),
      .rsp_keep        (rsp_keep),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- verif/tb_adjacent_line_group_filter_top.sv -----
// testbench of the adjacent line group filter: queued stimulus, line-group predictor, checker
module tb_adjacent_line_group_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import algf_pkg::*;

   localparam int LINE_BYTES = LINE_BYTES_DEFAULT;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // {only_repeated, only_single, fold_case} per phase
   localparam logic [2:0] CFG_SETTINGS [8] = '{3'b000, 3'b111, 3'b100, 3'b010,
                                               3'b001, 3'b011, 3'b110, 3'b101};

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] value;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_func = FUNC_BYTE;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_group_count;
   logic        rsp_keep;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ONLY_REPEATED;
   logic        csr_data = 1'b0;

   stream_item_type pending_items[$];
   rsp_type      expected_groups[$];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           mismatch_count = 0;

   // predictor state
   cfg_type      cur_cfg = '0;
   logic [7:0]   group_line [LINE_BYTES];
   int unsigned  stored_len = 0;
   int unsigned  incoming_len = 0;
   logic         line_differs = 1'b0;
   logic [31:0]  run_count = '0;
   logic         line_seen = 1'b0;
   int           step_emits;

   // text of the last generated line, used to build repeats and near misses
   logic [7:0]   prev_text[$];

   adjacent_line_group_filter_top #(.LINE_BYTES(LINE_BYTES)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_byte_value (req_byte_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_group_count(rsp_group_count),
      .rsp_keep       (rsp_keep),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] lower_letter(input logic [7:0] c);
      if (cur_cfg.fold_case && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic void emit_group(input logic [31:0] cnt);
      rsp_type r;
      r.group_count = cnt;
      r.keep = (!cur_cfg.only_repeated || cnt > 32'd1) &&
               (!cur_cfg.only_single || cnt == 32'd1);
      r.last = 1'b0;
      expected_groups.push_back(r);
      step_emits++;
   endfunction

   function automatic void finish_line();
      if (!line_seen) begin
         line_seen = 1'b1;
         run_count = 32'd1;
      end else if (!line_differs && incoming_len == stored_len) begin
         if (run_count != 32'hFFFF_FFFF) begin
            run_count++;
         end
      end else begin
         emit_group(run_count);
         run_count = 32'd1;
      end
      stored_len = incoming_len;
      incoming_len = 0;
      line_differs = 1'b0;
   endfunction

   function automatic void predict_groups(input logic [1:0] func, input logic [7:0] value);
      rsp_type tail;
      step_emits = 0;
      case (func)
         FUNC_BYTE: begin
            if (incoming_len < LINE_BYTES) begin
               if (line_seen && (incoming_len >= stored_len ||
                   lower_letter(group_line[incoming_len]) != lower_letter(value))) begin
                  line_differs = 1'b1;
               end
               group_line[incoming_len] = value;
               incoming_len++;
            end
            // a full-length line closes without an end of line
            if (incoming_len >= LINE_BYTES - 1) begin
               finish_line();
            end
         end
         FUNC_EOL: begin
            finish_line();
         end
         FUNC_EOS: begin
            if (incoming_len > 0) begin
               finish_line();
            end
            if (line_seen) begin
               emit_group(run_count);
            end
            stored_len = 0;
            incoming_len = 0;
            line_differs = 1'b0;
            run_count = '0;
            line_seen = 1'b0;
         end
         default: begin
         end
      endcase
      if (step_emits > 0) begin
         tail = expected_groups.pop_back();
         tail.last = 1'b1;
         expected_groups.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // driver: accept at the rising edge, present the next transaction at the falling edge
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_groups(req_func, req_byte_value);
         void'(pending_items.pop_front());
      end
   end

   always @(negedge clock) begin
      if (!reset && pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_push <= 1'b1;
         req_func <= pending_items[0].func;
         req_byte_value <= pending_items[0].value;
      end else begin
         req_push <= 1'b0;
      end
   end

   // monitor
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_groups.size() == 0) begin
            report_mismatch("unexpected result, group_count", rsp_group_count, 32'd0);
         end else begin
            want = expected_groups.pop_front();
            if (rsp_group_count != want.group_count) begin
               report_mismatch("group_count", rsp_group_count, want.group_count);
            end
            if (rsp_keep != want.keep) begin
               report_mismatch("keep", 32'(rsp_keep), 32'(want.keep));
            end
            if (rsp_last != want.last) begin
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
   end

   task automatic add_item(input logic [1:0] func, input logic [7:0] value);
      stream_item_type it;
      it.func = func;
      it.value = value;
      pending_items.push_back(it);
   endtask

   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 7))
         0: return 8'h61;
         1: return 8'h41;
         2: return 8'h62;
         3: return 8'h42;
         4: return 8'h63;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed lines that repeat or nearly repeat the previous one
   task automatic add_random_traffic(input int target);
      int added;
      int pick;
      int len;
      int pos;
      logic [1:0] noise_func;
      logic [7:0] line_buf[$];
      added = 0;
      while (added < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            noise_func = 2'($urandom_range(0, 3));
            add_item(noise_func, 8'($urandom_range(0, 255)));
            if (noise_func != FUNC_UNUSED) begin
               added++;
            end
         end else if (pick < 10) begin
            add_item(FUNC_EOS, 8'($urandom_range(0, 255)));
            added++;
         end else begin
            line_buf = prev_text;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               // exact repeat
            end else if (pick < 55) begin
               foreach (line_buf[i]) begin
                  if ((line_buf[i] | 8'h20) >= 8'h61 && (line_buf[i] | 8'h20) <= 8'h7A &&
                      $urandom_range(0, 1) == 1) begin
                     line_buf[i] = line_buf[i] ^ 8'h20;
                  end
               end
            end else if (pick < 65) begin
               if (line_buf.size() > 0) begin
                  pos = $urandom_range(0, line_buf.size() - 1);
                  line_buf[pos] = pick_text_byte();
               end
            end else if (pick < 75) begin
               if (line_buf.size() > 0 && $urandom_range(0, 1) == 1) begin
                  void'(line_buf.pop_back());
               end else begin
                  line_buf.push_back(pick_text_byte());
               end
            end else begin
               line_buf.delete();
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
               for (int i = 0; i < len; i++) begin
                  line_buf.push_back(pick_text_byte());
               end
            end
            foreach (line_buf[i]) begin
               add_item(FUNC_BYTE, line_buf[i]);
               added++;
            end
            // now and then leave the line open so the next one runs into it
            if ($urandom_range(0, 19) != 0) begin
               add_item(FUNC_EOL, 8'($urandom_range(0, 255)));
               added++;
            end
            prev_text = line_buf;
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ONLY_REPEATED: cur_cfg.only_repeated = val;
         CSR_ONLY_SINGLE:   cur_cfg.only_single = val;
         CSR_FOLD_CASE:     cur_cfg.fold_case = val;
         default: begin
         end
      endcase
   endtask

   // items may leave no result, so allow the pipeline to settle after the queues drain
   task automatic wait_until_drained();
      do @(negedge clock); while (pending_items.size() != 0 || expected_groups.size() != 0);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 8; p++) begin
         wait_until_drained();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         write_csr(CSR_ONLY_REPEATED, CFG_SETTINGS[p][2]);
         write_csr(CSR_ONLY_SINGLE, CFG_SETTINGS[p][1]);
         write_csr(CSR_FOLD_CASE, CFG_SETTINGS[p][0]);
         if (p == 0) begin
            add_item(FUNC_EOS, 8'h00);
            add_item(FUNC_UNUSED, 8'hFF);
            add_item(FUNC_BYTE, 8'h41);
            add_item(FUNC_BYTE, 8'h00);
            add_item(FUNC_EOL, 8'hFF);
            add_item(FUNC_BYTE, 8'h41);
            add_item(FUNC_BYTE, 8'h00);
            add_item(FUNC_EOL, 8'h00);
            add_item(FUNC_BYTE, 8'h0A);
            add_item(FUNC_EOL, 8'h55);
            add_item(FUNC_EOL, 8'hAA);
            add_item(FUNC_EOL, 8'h00);
            add_item(FUNC_BYTE, 8'hFF);
            add_item(FUNC_BYTE, 8'h01);
            // partial line and open group both flushed
            add_item(FUNC_EOS, 8'hFF);
            add_item(FUNC_EOS, 8'h00);
            add_item(FUNC_BYTE, 8'h61);
            add_item(FUNC_BYTE, 8'h42);
            add_item(FUNC_EOL, 8'h00);
            add_item(FUNC_BYTE, 8'h41);
            add_item(FUNC_BYTE, 8'h62);
            add_item(FUNC_EOL, 8'h00);
            add_item(FUNC_EOS, 8'h00);
         end
         add_random_traffic(250);
      end
      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("PASS adjacent_line_group_filter_top");
      end else begin
         $display("FAIL adjacent_line_group_filter_top");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL adjacent_line_group_filter_top");
      $finish;
   end

endmodule
